### design/assert_macros.svh
// assertion macros used by the depacketizer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/h264rtp_pkg.sv
// ----------------------------------------------------------------------------
// h264rtp_pkg
// types and constants for the h.264 rtp depacketizer
// ----------------------------------------------------------------------------
`default_nettype none

package h264rtp_pkg;

    // parse position within a packet
    localparam logic [3:0] POS_NAL  = 4'd12;  // nal header or payload indicator
    localparam logic [3:0] POS_FUH  = 4'd13;  // fu header
    localparam logic [3:0] POS_PAY  = 4'd14;  // payload
    localparam logic [3:0] POS_IDLE = 4'd15;  // between packets

    // rtp header byte positions that the parser acts on
    localparam logic [3:0] POS_RTP_FIRST  = 4'd0;
    localparam logic [3:0] POS_RTP_MARKER = 4'd1;
    localparam logic [3:0] POS_RTP_SEQ_HI = 4'd2;
    localparam logic [3:0] POS_RTP_SEQ_LO = 4'd3;

    // nal unit types
    localparam logic [4:0] NAL_TYPE_MASK_LOW = 5'd1;
    localparam logic [4:0] NAL_TYPE_SINGLE_HI = 5'd23;
    localparam logic [4:0] NAL_TYPE_STAP_A   = 5'h18;
    localparam logic [4:0] NAL_TYPE_FU_A     = 5'h1C;

    localparam logic [7:0] START_CODE_LAST = 8'h01;

    // results per word: none, one byte, start code, start code and one byte
    localparam logic [2:0] RUN_NONE       = 3'd0;
    localparam logic [2:0] RUN_BYTE       = 3'd1;
    localparam logic [2:0] RUN_START      = 3'd4;
    localparam logic [2:0] RUN_START_BYTE = 3'd5;

    typedef enum logic [1:0] {
        KIND_DROP,
        KIND_SINGLE,
        KIND_STAP,
        KIND_FU
    } kind_t;

    typedef enum logic [1:0] {
        PHASE_LEN_HI,
        PHASE_LEN_LO,
        PHASE_NAL
    } phase_t;

endpackage

`default_nettype wire

### design/h264_rtp_depacketizer.sv
// ----------------------------------------------------------------------------
// h264_rtp_depacketizer
// rtp packets carrying h.264, one byte per word, in; annex b byte stream out
// ----------------------------------------------------------------------------
// Each input word is parsed as it is accepted: the 12-byte rtp header is
// consumed (marker bit and sequence number kept), single nal packets and
// fu-a start fragments get a 00 00 00 01 start code and the nal header,
// stap-a packets are split on their 16-bit length prefixes with a start code
// per non-empty nal, and other packet types are dropped. The word's results
// (zero, one, four or five bytes) are loaded into a small run register that
// the output side drains at one byte per cycle while result_ready is high. A
// new input word is taken in the same cycle that the last byte of the
// previous run leaves, so payload flows at one byte per cycle when neither
// side stalls. A word with a start code holds the input until its whole run
// has left; words that make no output do not hold it. A word's first output
// byte is presented in the cycle after the word is accepted.
// sequence_gap flags the first output byte after a sequence number skip;
// unit_end flags the last byte made by the last word of a marked packet.
// ----------------------------------------------------------------------------
`default_nettype none

module h264_rtp_depacketizer
    import h264rtp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // input words
    input  wire logic       item_valid,
    output logic            item_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       packet_first,
    input  wire logic       packet_last,
    // result words
    output logic            result_valid,
    input  wire logic       result_ready,
    output logic [7:0]      out_byte,
    output logic            run_last,
    output logic            unit_end,
    output logic            sequence_gap
);

    // parser state
    logic [3:0]  position_reg, position_next;
    kind_t       kind_reg, kind_next;
    logic        marker_reg, marker_next;
    logic [2:0]  nri_reg, nri_next;
    phase_t      phase_reg, phase_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [15:0] prev_seq_reg, prev_seq_next;
    logic        seq_valid_reg, seq_valid_next;
    logic [7:0]  seq_hi_reg, seq_hi_next;
    logic        gap_pending_reg, gap_pending_next;

    // run register: bytes still to send for the current word
    logic [2:0]  left_reg, left_next;
    logic        has_byte_reg, has_byte_next;
    logic [7:0]  byte_reg, byte_next;
    logic        first_reg;
    logic        ue_reg, ue_next;
    logic        gap_reg, gap_next;

    logic        in_accept;
    logic        out_accept;
    logic [2:0]  run_len;
    logic [15:0] seq_now;
    logic        gap_now;
    logic [4:0]  nal_type;

    // take a new word when the run register empties this cycle
    assign item_ready   = (left_reg == RUN_NONE) || (left_reg == RUN_BYTE && result_ready);
    assign in_accept    = item_valid && item_ready;
    assign result_valid = (left_reg != RUN_NONE);
    assign out_accept   = result_valid && result_ready;

    assign nal_type = data_byte[4:0];
    assign seq_now  = {seq_hi_reg, data_byte};

    // parse one word
    always_comb
    begin
        position_next    = position_reg;
        kind_next        = kind_reg;
        marker_next      = marker_reg;
        nri_next         = nri_reg;
        phase_next       = phase_reg;
        remaining_next   = remaining_reg;
        prev_seq_next    = prev_seq_reg;
        seq_valid_next   = seq_valid_reg;
        seq_hi_next      = seq_hi_reg;
        gap_now          = gap_pending_reg;
        run_len          = RUN_NONE;
        byte_next        = data_byte;

        // packet start restarts the header from any state
        if (packet_first)
        begin
            position_next = POS_RTP_FIRST;
            kind_next     = KIND_DROP;
        end

        if (position_next < POS_NAL)
        begin
            case (position_next)
                POS_RTP_FIRST:  marker_next = 1'b0;
                POS_RTP_MARKER: marker_next = data_byte[7];
                POS_RTP_SEQ_HI: seq_hi_next = data_byte;
                POS_RTP_SEQ_LO:
                begin
                    if (seq_valid_reg && (seq_now != prev_seq_reg + 16'd1))
                        gap_now = 1'b1;
                    prev_seq_next  = seq_now;
                    seq_valid_next = 1'b1;
                end
                default: ;
            endcase
            position_next = position_next + 4'd1;
        end
        else if (position_next == POS_NAL)
        begin
            if (nal_type >= NAL_TYPE_MASK_LOW && nal_type <= NAL_TYPE_SINGLE_HI)
            begin
                kind_next     = KIND_SINGLE;
                run_len       = RUN_START_BYTE;
                position_next = POS_PAY;
            end
            else if (nal_type == NAL_TYPE_STAP_A)
            begin
                kind_next      = KIND_STAP;
                phase_next     = PHASE_LEN_HI;
                remaining_next = 16'd0;
                position_next  = POS_PAY;
            end
            else if (nal_type == NAL_TYPE_FU_A)
            begin
                kind_next     = KIND_FU;
                nri_next      = data_byte[7:5];
                position_next = POS_FUH;
            end
            else
            begin
                kind_next     = KIND_DROP;
                position_next = POS_PAY;
            end
        end
        else if (position_next == POS_FUH)
        begin
            // start fragment rebuilds the nal header
            if (data_byte[7])
            begin
                run_len   = RUN_START_BYTE;
                byte_next = {nri_reg, data_byte[4:0]};
            end
            position_next = POS_PAY;
        end
        else if (position_next == POS_PAY)
        begin
            case (kind_next)
                KIND_SINGLE, KIND_FU: run_len = RUN_BYTE;
                KIND_STAP:
                begin
                    case (phase_reg)
                        PHASE_LEN_HI:
                        begin
                            remaining_next = {data_byte, 8'd0};
                            phase_next     = PHASE_LEN_LO;
                        end
                        PHASE_LEN_LO:
                        begin
                            remaining_next = {remaining_reg[15:8], data_byte};
                            if (remaining_next == 16'd0)
                                phase_next = PHASE_LEN_HI;
                            else
                            begin
                                run_len    = RUN_START;
                                phase_next = PHASE_NAL;
                            end
                        end
                        default:
                        begin
                            run_len        = RUN_BYTE;
                            remaining_next = remaining_reg - 16'd1;
                            if (remaining_next == 16'd0)
                                phase_next = PHASE_LEN_HI;
                        end
                    endcase
                end
                default: ;
            endcase
        end

        if (packet_last)
            position_next = POS_IDLE;

        // gap stays pending until a word emits something
        gap_pending_next = gap_now && (run_len == RUN_NONE);
        gap_next         = gap_now && (run_len != RUN_NONE);
        ue_next          = packet_last && marker_next;
        has_byte_next    = (run_len != RUN_START);
    end

    // run register next count
    always_comb
    begin
        if (in_accept)
            left_next = run_len;
        else if (out_accept)
            left_next = left_reg - 3'd1;
        else
            left_next = left_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg    <= POS_RTP_FIRST;
            kind_reg        <= KIND_DROP;
            marker_reg      <= 1'b0;
            nri_reg         <= 3'd0;
            phase_reg       <= PHASE_LEN_HI;
            remaining_reg   <= 16'd0;
            prev_seq_reg    <= 16'd0;
            seq_valid_reg   <= 1'b0;
            seq_hi_reg      <= 8'd0;
            gap_pending_reg <= 1'b0;
            left_reg        <= RUN_NONE;
            first_reg       <= 1'b0;
            ue_reg          <= 1'b0;
            gap_reg         <= 1'b0;
        end
        else
        begin
            left_reg <= left_next;
            if (in_accept)
            begin
                position_reg    <= position_next;
                kind_reg        <= kind_next;
                marker_reg      <= marker_next;
                nri_reg         <= nri_next;
                phase_reg       <= phase_next;
                remaining_reg   <= remaining_next;
                prev_seq_reg    <= prev_seq_next;
                seq_valid_reg   <= seq_valid_next;
                seq_hi_reg      <= seq_hi_next;
                gap_pending_reg <= gap_pending_next;
                first_reg       <= 1'b1;
                ue_reg          <= ue_next;
                gap_reg         <= gap_next;
            end
            else if (out_accept)
                first_reg <= 1'b0;
        end
    end

    // run payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            byte_reg     <= byte_next;
            has_byte_reg <= has_byte_next;
        end
    end

    // byte select: trailing data byte, start code 01, else start code 00
    always_comb
    begin
        if (left_reg == RUN_BYTE && has_byte_reg)
            out_byte = byte_reg;
        else if ((left_reg == RUN_BYTE) || (left_reg == 3'd2 && has_byte_reg))
            out_byte = START_CODE_LAST;
        else
            out_byte = 8'd0;
    end

    assign run_last     = (left_reg == RUN_BYTE);
    assign unit_end     = run_last && ue_reg;
    assign sequence_gap = first_reg && gap_reg;

`include "assert_macros.svh"

    `ASSERT_CLK(a_no_accept_mid_run, clk, rst_n, (left_reg > RUN_BYTE) |-> !item_ready, "input taken while a run is still pending")
    `ASSERT_CLK(a_unit_end_last, clk, rst_n, (result_valid && unit_end) |-> run_last, "unit_end away from the last byte of a run")
    `ASSERT_CLK(a_start_code_zero, clk, rst_n, (result_valid && first_reg && left_reg >= RUN_START) |-> (out_byte == 8'd0), "start code does not open with zero")
    `ASSERT_ALWAYS(a_run_len_range, clk, (left_reg <= RUN_START_BYTE), "run count out of range")

endmodule

`default_nettype wire

### tb/tb_h264_rtp_depacketizer.sv
// ----------------------------------------------------------------------------
// tb_h264_rtp_depacketizer
// self-checking bench for the h.264 rtp depacketizer
// ----------------------------------------------------------------------------
// Packets are sent one byte per word with random gaps on the input side and
// random stalls on the output side. A behavioral model of the parser runs on
// every accepted input word and queues the annex b bytes it should produce.
// Every output word is compared field by field with the oldest queued byte.
// Directed packets cover each packet type and corner case first. Random
// packets follow, mostly well formed, with some noise mixed in.
// ----------------------------------------------------------------------------

module tb_h264_rtp_depacketizer
    import h264rtp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 190;

    // one expected output word
    typedef struct packed {
        logic [7:0] value;
        logic       ends_run;
        logic       ends_unit;
        logic       after_gap;
    } stream_byte_t;

    logic       clk;
    logic       rst_n;
    logic       item_valid;
    logic       item_ready;
    logic [7:0] data_byte;
    logic       packet_first;
    logic       packet_last;
    logic       result_valid;
    logic       result_ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       unit_end;
    logic       sequence_gap;

    h264_rtp_depacketizer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .data_byte    (data_byte),
        .packet_first (packet_first),
        .packet_last  (packet_last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_byte     (out_byte),
        .run_last     (run_last),
        .unit_end     (unit_end),
        .sequence_gap (sequence_gap)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // parser model state
    logic [3:0]  hdr_pos;
    kind_t       kind;
    logic        marker;
    logic [2:0]  fu_nri;
    phase_t      stap_phase;
    logic [15:0] stap_left;
    logic [15:0] prev_seq;
    logic        seq_known;
    logic [7:0]  seq_hi;
    logic        gap_flag;

    // bytes made by the current word, before they are queued
    logic [7:0]   word_run [5];
    int           run_len;
    stream_byte_t annexb_expected [$];

    // packet under construction and bookkeeping
    logic [7:0]   pkt_bytes [$];
    logic [15:0]  next_seq;
    bit           steady;
    int           errors;
    int           cycles;
    int           words_counted;
    int           packets_sent;
    int           bytes_checked;
    int           gaps_seen;
    int           units_seen;
    stream_byte_t head;

    // ------------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] b);
        word_run[run_len] = b;
        run_len++;
    endtask

    task automatic add_start_code();
        add_byte(8'h00);
        add_byte(8'h00);
        add_byte(8'h00);
        add_byte(START_CODE_LAST);
    endtask

    task automatic depacketize_word(input logic [7:0] b, input logic first,
                                    input logic last);
        logic [15:0]  seq;
        stream_byte_t sb;
        int           i;
        run_len = 0;
        // packet_first restarts parsing wherever we are
        if (first)
        begin
            hdr_pos = POS_RTP_FIRST;
            kind = KIND_DROP;
        end
        if (hdr_pos < POS_NAL)
        begin
            // rtp header: keep marker and sequence number only
            case (hdr_pos)
                POS_RTP_FIRST:  marker = 1'b0;
                POS_RTP_MARKER: marker = b[7];
                POS_RTP_SEQ_HI: seq_hi = b;
                POS_RTP_SEQ_LO:
                begin
                    seq = {seq_hi, b};
                    if (seq_known && seq != prev_seq + 16'd1)
                        gap_flag = 1'b1;
                    prev_seq = seq;
                    seq_known = 1'b1;
                end
                default: ;
            endcase
            hdr_pos = hdr_pos + 4'd1;
        end
        else if (hdr_pos == POS_NAL)
        begin
            if (b[4:0] >= NAL_TYPE_MASK_LOW && b[4:0] <= NAL_TYPE_SINGLE_HI)
            begin
                kind = KIND_SINGLE;
                add_start_code();
                add_byte(b);
                hdr_pos = POS_PAY;
            end
            else if (b[4:0] == NAL_TYPE_STAP_A)
            begin
                kind = KIND_STAP;
                stap_phase = PHASE_LEN_HI;
                stap_left = 16'd0;
                hdr_pos = POS_PAY;
            end
            else if (b[4:0] == NAL_TYPE_FU_A)
            begin
                kind = KIND_FU;
                fu_nri = b[7:5];
                hdr_pos = POS_FUH;
            end
            else
            begin
                kind = KIND_DROP;
                hdr_pos = POS_PAY;
            end
        end
        else if (hdr_pos == POS_FUH)
        begin
            // start fragment rebuilds the nal header
            if (b[7])
            begin
                add_start_code();
                add_byte({fu_nri, b[4:0]});
            end
            hdr_pos = POS_PAY;
        end
        else if (hdr_pos == POS_PAY)
        begin
            case (kind)
                KIND_SINGLE, KIND_FU: add_byte(b);
                KIND_STAP:
                begin
                    case (stap_phase)
                        PHASE_LEN_HI:
                        begin
                            stap_left = {b, 8'h00};
                            stap_phase = PHASE_LEN_LO;
                        end
                        PHASE_LEN_LO:
                        begin
                            stap_left = stap_left | {8'h00, b};
                            // empty nal: no start code
                            if (stap_left == 16'd0)
                                stap_phase = PHASE_LEN_HI;
                            else
                            begin
                                add_start_code();
                                stap_phase = PHASE_NAL;
                            end
                        end
                        default:
                        begin
                            add_byte(b);
                            stap_left = stap_left - 16'd1;
                            if (stap_left == 16'd0)
                                stap_phase = PHASE_LEN_HI;
                        end
                    endcase
                end
                default: ;
            endcase
        end

        for (i = 0; i < run_len; i++)
        begin
            sb.value     = word_run[i];
            sb.ends_run  = (i == run_len - 1);
            sb.ends_unit = (i == run_len - 1) && last && marker;
            sb.after_gap = (i == 0) && gap_flag;
            annexb_expected.push_back(sb);
        end
        // a pending gap waits for the next byte that comes out
        if (run_len > 0)
            gap_flag = 1'b0;
        if (last)
            hdr_pos = POS_IDLE;
    endtask

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [7:0] b, input logic first, input logic last);
        if (!steady)
            while ($urandom_range(99) < 32)
            begin
                item_valid <= 1'b0;
                @(posedge clk);
            end
        item_valid   <= 1'b1;
        data_byte    <= b;
        packet_first <= first;
        packet_last  <= last;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        // stray bytes between packets are not counted
        if (first || hdr_pos != POS_IDLE)
            words_counted++;
        depacketize_word(b, first, last);
    endtask

    task automatic send_packet(input bit with_first, input bit with_last);
        int i;
        for (i = 0; i < pkt_bytes.size(); i++)
            send_word(pkt_bytes[i], with_first && i == 0,
                      with_last && i == pkt_bytes.size() - 1);
    endtask

    // rtp header with a chosen marker; skip makes the sequence number jump
    task automatic build_header(input logic marked, input logic skip);
        logic [15:0] seq;
        seq = skip ? next_seq + 16'($urandom_range(65534, 1)) : next_seq;
        next_seq = seq + 16'd1;
        pkt_bytes.delete();
        pkt_bytes.push_back(8'($urandom));
        pkt_bytes.push_back({marked, 7'($urandom)});
        pkt_bytes.push_back(seq[15:8]);
        pkt_bytes.push_back(seq[7:0]);
        repeat (8)
            pkt_bytes.push_back(8'($urandom));
        packets_sent++;
    endtask

    task automatic add_payload(input int n);
        repeat (n)
            pkt_bytes.push_back(8'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------------
    always @(posedge clk)
        result_ready <= steady || ($urandom_range(99) >= 32);

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (annexb_expected.size() == 0)
            begin
                $error("out_byte %02h arrived with nothing expected", out_byte);
                errors++;
            end
            else
            begin
                head = annexb_expected.pop_front();
                bytes_checked++;
                if (sequence_gap)
                    gaps_seen++;
                if (unit_end)
                    units_seen++;
                if (out_byte !== head.value)
                begin
                    $error("out_byte: expected %02h, got %02h", head.value, out_byte);
                    errors++;
                end
                if (run_last !== head.ends_run)
                begin
                    $error("run_last: expected %0b, got %0b", head.ends_run, run_last);
                    errors++;
                end
                if (unit_end !== head.ends_unit)
                begin
                    $error("unit_end: expected %0b, got %0b", head.ends_unit, unit_end);
                    errors++;
                end
                if (sequence_gap !== head.after_gap)
                begin
                    $error("sequence_gap: expected %0b, got %0b", head.after_gap,
                           sequence_gap);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("h264_rtp_depacketizer: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // very first packet has no packet_first flag; data extremes, marker set
    task automatic test_first_without_flag();
        build_header(1'b1, 1'b0);
        pkt_bytes.push_back(8'h01);
        pkt_bytes.push_back(8'h00);
        pkt_bytes.push_back(8'hFF);
        send_packet(1'b0, 1'b1);
    endtask

    // highest single type with f and nri set, sequence wraps without a gap,
    // then stray words between packets that must be ignored
    task automatic test_single_nal();
        build_header(1'b0, 1'b0);
        pkt_bytes.push_back(8'hF7);
        pkt_bytes.push_back(8'hA5);
        send_packet(1'b1, 1'b1);
        send_word(8'h3C, 1'b0, 1'b0);
        send_word(8'hC3, 1'b0, 1'b1);
    endtask

    // stap-a with an empty nal and a last nal cut short by the packet end
    task automatic test_stap_a();
        build_header(1'b1, 1'b1);
        pkt_bytes.push_back({3'b011, NAL_TYPE_STAP_A});
        pkt_bytes.push_back(8'h00);
        pkt_bytes.push_back(8'h02);
        add_payload(2);
        pkt_bytes.push_back(8'h00);
        pkt_bytes.push_back(8'h00);
        pkt_bytes.push_back(8'h00);
        pkt_bytes.push_back(8'h01);
        add_payload(1);
        pkt_bytes.push_back(8'hFF);
        pkt_bytes.push_back(8'h03);
        add_payload(2);
        send_packet(1'b1, 1'b1);
    endtask

    // fu-a start, middle and end fragments, plus a start with no payload
    task automatic test_fu_a();
        build_header(1'b0, 1'b0);
        pkt_bytes.push_back({3'b011, NAL_TYPE_FU_A});
        pkt_bytes.push_back(8'h85);
        add_payload(2);
        send_packet(1'b1, 1'b1);
        build_header(1'b0, 1'b0);
        pkt_bytes.push_back({3'b111, NAL_TYPE_FU_A});
        pkt_bytes.push_back(8'h05);
        add_payload(1);
        send_packet(1'b1, 1'b1);
        build_header(1'b1, 1'b0);
        pkt_bytes.push_back({3'b010, NAL_TYPE_FU_A});
        pkt_bytes.push_back(8'h45);
        add_payload(1);
        send_packet(1'b1, 1'b1);
        build_header(1'b1, 1'b0);
        pkt_bytes.push_back({3'b001, NAL_TYPE_FU_A});
        pkt_bytes.push_back(8'h81);
        send_packet(1'b1, 1'b1);
    endtask

    // dropped types, truncated packets and a restart in mid packet; the gap
    // raised by the dropped packet must wait for the next output byte
    task automatic test_drop_and_truncation();
        build_header(1'b1, 1'b1);
        pkt_bytes.push_back(8'h00);
        add_payload(2);
        send_packet(1'b1, 1'b1);
        build_header(1'b0, 1'b0);
        pkt_bytes.push_back(8'hFF);
        add_payload(1);
        send_packet(1'b1, 1'b1);
        build_header(1'b1, 1'b0);
        pkt_bytes = pkt_bytes[0:4];
        send_packet(1'b1, 1'b1);
        build_header(1'b0, 1'b0);
        pkt_bytes.push_back({3'b000, NAL_TYPE_FU_A});
        send_packet(1'b1, 1'b1);
        build_header(1'b0, 1'b0);
        pkt_bytes.push_back(8'h41);
        add_payload(2);
        send_packet(1'b1, 1'b0);
        build_header(1'b1, 1'b0);
        pkt_bytes.push_back(8'h65);
        add_payload(1);
        send_packet(1'b1, 1'b1);
    endtask

    task automatic random_packet();
        int pick;
        int n;
        int len;
        int cut;
        pick = $urandom_range(99);
        build_header(1'($urandom), $urandom_range(99) < 8);
        if (pick < 30 || pick >= 88)
        begin
            pkt_bytes.push_back({3'($urandom), 5'($urandom_range(23, 1))});
            add_payload($urandom_range(6));
        end
        else if (pick < 55)
        begin
            pkt_bytes.push_back({3'($urandom), NAL_TYPE_STAP_A});
            n = $urandom_range(3, 1);
            repeat (n)
            begin
                len = ($urandom_range(9) == 0) ? 0 : $urandom_range(4, 1);
                // now and then a huge length that the packet cuts short
                pkt_bytes.push_back(($urandom_range(19) == 0) ? 8'($urandom) : 8'h00);
                pkt_bytes.push_back(8'(len));
                add_payload(len);
            end
        end
        else if (pick < 80)
        begin
            pkt_bytes.push_back({3'($urandom), NAL_TYPE_FU_A});
            pkt_bytes.push_back(8'($urandom));
            add_payload($urandom_range(6));
        end
        else
        begin
            case ($urandom_range(6))
                0: pkt_bytes.push_back({3'($urandom), 5'd0});
                1: pkt_bytes.push_back({3'($urandom), 5'd25});
                2: pkt_bytes.push_back({3'($urandom), 5'd26});
                3: pkt_bytes.push_back({3'($urandom), 5'd27});
                4: pkt_bytes.push_back({3'($urandom), 5'd29});
                5: pkt_bytes.push_back({3'($urandom), 5'd30});
                default: pkt_bytes.push_back({3'($urandom), 5'd31});
            endcase
            add_payload($urandom_range(4));
        end

        if (pick >= 88 && pick < 94)
        begin
            // truncated anywhere, down to a single byte
            cut = $urandom_range(pkt_bytes.size(), 1);
            while (pkt_bytes.size() > cut)
                void'(pkt_bytes.pop_back());
            send_packet(1'b1, 1'b1);
        end
        else if (pick >= 94 && pick < 97)
            send_packet(1'b1, 1'b0);
        else if (pick >= 97)
            send_packet(1'b0, 1'($urandom));
        else
            send_packet(1'b1, 1'b1);
    endtask

    task automatic test_random();
        int base;
        base = words_counted;
        while (words_counted < base + RANDOM_WORDS)
        begin
            // one long stretch with neither side idling
            steady = (words_counted - base >= 50) && (words_counted - base < 130);
            random_packet();
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        item_valid   <= 1'b0;
        data_byte    <= 8'h00;
        packet_first <= 1'b0;
        packet_last  <= 1'b0;
        result_ready <= 1'b0;
        rst_n        <= 1'b0;
        steady = 1'b0;
        errors = 0;
        cycles = 0;
        words_counted = 0;
        packets_sent = 0;
        bytes_checked = 0;
        gaps_seen = 0;
        units_seen = 0;
        next_seq = 16'hFFFF;
        hdr_pos = POS_RTP_FIRST;
        kind = KIND_DROP;
        marker = 1'b0;
        fu_nri = 3'd0;
        stap_phase = PHASE_LEN_HI;
        stap_left = 16'd0;
        prev_seq = 16'd0;
        seq_known = 1'b0;
        seq_hi = 8'h00;
        gap_flag = 1'b0;

        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_first_without_flag();
        test_single_nal();
        test_stap_a();
        test_fu_a();
        test_drop_and_truncation();
        test_random();

        item_valid <= 1'b0;
        while (annexb_expected.size() != 0)
            @(posedge clk);
        // let any stray output show up
        repeat (20)
            @(posedge clk);

        $display("%0d words in %0d packets sent, %0d stream bytes checked",
                 words_counted, packets_sent, bytes_checked);
        $display("%0d sequence gaps and %0d access unit ends seen", gaps_seen, units_seen);
        if (errors == 0)
            $display("h264_rtp_depacketizer: match");
        else
            $display("h264_rtp_depacketizer: mismatch");
        $finish;
    end

endmodule
